// ===== rtl/pscs_pkg.sv =====
// Shared constants and types for the scanline crossing sorter.
`timescale 1ns / 1ps
package pscs_pkg;
  localparam int MAX_CROSSINGS = 60;
  localparam int COORD_WIDTH = 32;
  localparam int MARGINS = 4;
  localparam int IDX_W = $clog2(MAX_CROSSINGS);
  localparam int CNT_W = $clog2(MAX_CROSSINGS + 1);
  localparam int OUT_W = $clog2(MAX_CROSSINGS + MARGINS + 1);
  localparam int MAG_W = COORD_WIDTH + 1;
  localparam int DIV_STEPS = COORD_WIDTH + 2;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);
  localparam int NUM_REGS = 6;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_SCAN_Z = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_OUTER = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_INNER = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_INNER = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_OUTER = 3'd5;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t edge_start_x;
    coord_t edge_start_y;
    coord_t edge_end_x;
    coord_t edge_end_y;
    logic   last_edge;
  } edge_t;

  typedef struct packed {
    coord_t boundary_x;
    logic   device_after;
    logic   overflow;
    logic   last_boundary;
  } boundary_t;
endpackage

// ===== rtl/pscs_stream_if.sv =====
// Valid/ready stream interface carrying one payload beat.
`timescale 1ns / 1ps
interface pscs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pscs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pscs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/polygon_scanline_crossing_sorter.sv =====
// Top level of the scanline polygon crossing sorter.
`timescale 1ns / 1ps
//
// Usage: edges enter on edge_in, one beat per edge with the closing edge of
// every polygon sent as a normal edge. Registers (scan_z, shift_x and the
// four margins) are written through cfg_we/cfg_index/cfg_data while idle.
// An edge that crosses the scan line (lower end inclusive) gets its crossing
// x from a bit-serial multiply-divide of COORD_WIDTH+1 steps, then is sorted
// into the crossing RAM by an insertion walk: one read-modify-write per entry
// moved, from the top of the store down to the insertion point.
// Edges are taken only while idle: the next edge waits until the divider
// and the insertion walk on the single RAM port are through with this one.
// On an edge marked last_edge the block streams count+4 boundary beats on
// boundary_out: two left margins, the shifted, saturated crossings, two
// right margins. A margin beat loads straight into the output register; a
// crossing beat is read from the RAM first, then loaded, when the sink is
// ready. The first beat loads in ST_OUT, after ST_CHECK. A stalled sink holds
// the output register and freezes the stream; no edge is taken until the
// last beat is loaded. Reset clears registers, count, overflow flag and
// control; the RAM contents stay undefined and only entries below the count
// are ever used.
module polygon_scanline_crossing_sorter (
  input  logic                              clk,
  input  logic                              rst,
  pscs_stream_if.sink                       edge_in,
  pscs_stream_if.source                     boundary_out,
  input  logic                              cfg_we,
  input  logic [pscs_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [pscs_pkg::COORD_WIDTH-1:0]  cfg_data
);
  import pscs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV = 3'd1;
  localparam logic [2:0] ST_INS_RD = 3'd2;
  localparam logic [2:0] ST_INS_CMP = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;

  logic [2:0] state;

  // configuration
  coord_t scan_z, shift_x, left_outer_edge, left_inner_edge;
  coord_t right_inner_edge, right_outer_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_z <= '0;
      shift_x <= '0;
      left_outer_edge <= '0;
      left_inner_edge <= '0;
      right_inner_edge <= '0;
      right_outer_edge <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_Z:      scan_z <= cfg_data;
        REG_SHIFT_X:     shift_x <= cfg_data;
        REG_LEFT_OUTER:  left_outer_edge <= cfg_data;
        REG_LEFT_INNER:  left_inner_edge <= cfg_data;
        REG_RIGHT_INNER: right_inner_edge <= cfg_data;
        REG_RIGHT_OUTER: right_outer_edge <= cfg_data;
        default: ;
      endcase
    end
  end

  // run state
  logic [CNT_W-1:0] crossing_count;
  logic             overflow_flag;
  logic             last_pending;

  // divider: floor(a*b/c), one bit of a per step
  logic [MAG_W-1:0]  div_a, div_b, div_c, div_q;
  logic [MAG_W+1:0]  div_r;
  logic [STEP_W-1:0] div_step;
  logic              dx_neg;
  coord_t            x0;
  coord_t            new_x;

  // insertion walk
  logic [CNT_W-1:0] ins_pos;

  // RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  coord_t           ram_wdata, ram_rdata;

  pscs_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_CROSSINGS)) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // output sequencing
  logic [OUT_W-1:0] out_k, out_n;
  logic             out_rd_pending; // a RAM read for beat out_k is in flight
  logic             out_valid;
  boundary_t        out_beat;

  // edge decode
  edge_t e;
  logic  crosses;
  logic signed [COORD_WIDTH:0] dx_w, dz_w, dy_w;
  assign e = edge_in.data;
  assign crosses = (e.edge_start_y <= scan_z && scan_z < e.edge_end_y) ||
                   (e.edge_end_y <= scan_z && scan_z < e.edge_start_y);
  assign dx_w = {e.edge_end_x[COORD_WIDTH-1], e.edge_end_x} -
                {e.edge_start_x[COORD_WIDTH-1], e.edge_start_x};
  assign dz_w = {scan_z[COORD_WIDTH-1], scan_z} -
                {e.edge_start_y[COORD_WIDTH-1], e.edge_start_y};
  assign dy_w = {e.edge_end_y[COORD_WIDTH-1], e.edge_end_y} -
                {e.edge_start_y[COORD_WIDTH-1], e.edge_start_y};

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [COORD_WIDTH:0] v);
    return v[COORD_WIDTH] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  // divider step
  logic [MAG_W+1:0] r1, r2;
  logic [MAG_W-1:0] q1, q2;
  always_comb begin
    r1 = {div_r[MAG_W:0], 1'b0};
    q1 = {div_q[MAG_W-2:0], 1'b0};
    if (r1 >= {2'b00, div_c}) begin
      r1 = r1 - {2'b00, div_c};
      q1 = q1 + 1'b1;
    end
    r2 = r1;
    q2 = q1;
    if (div_a[MAG_W-1]) begin
      r2 = r1 + {2'b00, div_b};
      if (r2 >= {2'b00, div_c}) begin
        r2 = r2 - {2'b00, div_c};
        q2 = q1 + 1'b1;
      end
    end
  end

  // saturated shifted crossing
  logic signed [COORD_WIDTH:0] shifted;
  coord_t sat_x;
  always_comb begin
    shifted = {ram_rdata[COORD_WIDTH-1], ram_rdata} + {shift_x[COORD_WIDTH-1], shift_x};
    if (shifted[COORD_WIDTH] != shifted[COORD_WIDTH-1]) begin
      sat_x = shifted[COORD_WIDTH] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                   : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      sat_x = shifted[COORD_WIDTH-1:0];
    end
  end

  logic out_take;
  assign out_take = out_valid && boundary_out.ready;
  // output register may load when empty or being drained
  logic out_free;
  assign out_free = !out_valid || boundary_out.ready;

  assign edge_in.ready = (state == ST_IDLE);
  assign boundary_out.valid = out_valid;
  assign boundary_out.data = out_beat;

  // RAM address/write control
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    case (state)
      ST_INS_RD: begin
        ram_raddr = IDX_W'(ins_pos - 1'b1);
      end
      ST_INS_CMP: begin
        ram_raddr = IDX_W'(ins_pos - 2'd2);
        if (ins_pos != '0 && ram_rdata > new_x) begin
          ram_we = 1'b1;
          ram_waddr = IDX_W'(ins_pos);
          ram_wdata = ram_rdata;
        end else begin
          ram_we = 1'b1;
          ram_waddr = IDX_W'(ins_pos);
          ram_wdata = new_x;
        end
      end
      ST_OUT: begin
        ram_raddr = IDX_W'(out_k - 2'd2);
      end
      default: ;
    endcase
  end

  // next beat index to present and whether it needs RAM data
  logic is_cross;
  assign is_cross = (out_k >= OUT_W'(2)) && (out_k < out_n - OUT_W'(2));

  // load the output register with beat out_k this cycle
  logic out_load;
  assign out_load = (state == ST_OUT) && out_free && !(is_cross && !out_rd_pending);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      crossing_count <= '0;
      overflow_flag <= 1'b0;
      last_pending <= 1'b0;
      out_rd_pending <= 1'b0;
      out_k <= '0;
      out_n <= '0;
      div_step <= '0;
      ins_pos <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (edge_in.valid) begin
            last_pending <= e.last_edge;
            x0 <= e.edge_start_x;
            dx_neg <= dx_w[COORD_WIDTH];
            if (crosses) begin
              div_a <= mag_of(dx_w);
              div_b <= mag_of(dz_w);
              div_c <= mag_of(dy_w);
              div_q <= '0;
              div_r <= '0;
              div_step <= '0;
              state <= ST_DIV;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_DIV: begin
          // leading zero steps of the reference loop are absorbed by MAG_W
          div_r <= r2;
          div_q <= q2;
          div_a <= {div_a[MAG_W-2:0], 1'b0};
          if (div_step == STEP_W'(MAG_W - 1)) begin
            new_x <= dx_neg ? COORD_WIDTH'(x0 - q2[COORD_WIDTH-1:0])
                            : COORD_WIDTH'(x0 + q2[COORD_WIDTH-1:0]);
            if (crossing_count == CNT_W'(MAX_CROSSINGS)) begin
              overflow_flag <= 1'b1;
              state <= ST_CHECK;
            end else begin
              ins_pos <= crossing_count;
              state <= ST_INS_RD;
            end
          end
          div_step <= div_step + 1'b1;
        end
        ST_INS_RD: begin
          if (ins_pos == '0) begin
            // empty store: write directly through the compare state
            state <= ST_INS_CMP;
          end else begin
            state <= ST_INS_CMP;
          end
        end
        ST_INS_CMP: begin
          if (ins_pos != '0 && ram_rdata > new_x) begin
            ins_pos <= ins_pos - 1'b1;
            // read for the next lower entry was issued this cycle
          end else begin
            crossing_count <= crossing_count + 1'b1;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (last_pending) begin
            out_n <= OUT_W'(crossing_count) + OUT_W'(MARGINS);
            out_k <= '0;
            out_rd_pending <= 1'b0;
            state <= ST_OUT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            if (is_cross && !out_rd_pending) begin
              // issue read this cycle; the beat loads once out_rd_pending is set and the register is free
              out_rd_pending <= 1'b1;
            end else begin
              out_rd_pending <= 1'b0;
              out_beat.device_after <= !out_k[0] && out_k >= OUT_W'(2) &&
                                       out_k + OUT_W'(4) <= out_n;
              out_beat.overflow <= overflow_flag;
              out_beat.last_boundary <= (out_k == out_n - 1'b1);
              if (out_k == '0) out_beat.boundary_x <= left_outer_edge;
              else if (out_k == OUT_W'(1)) out_beat.boundary_x <= left_inner_edge;
              else if (out_k == out_n - OUT_W'(2)) out_beat.boundary_x <= right_inner_edge;
              else if (out_k == out_n - 1'b1) out_beat.boundary_x <= right_outer_edge;
              else out_beat.boundary_x <= sat_x;
              out_k <= out_k + 1'b1;
              if (out_k == out_n - 1'b1) begin
                crossing_count <= '0;
                overflow_flag <= 1'b0;
                state <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    crossing_count <= CNT_W'(MAX_CROSSINGS))
    else $error("crossing count above capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !edge_in.ready)
    else $error("edge accepted while busy");
  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_k == out_n - 1'b1) |=> (crossing_count == '0))
    else $error("run end did not clear count");
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("store written while idle");
`endif
endmodule

// ===== dv/polygon_scanline_crossing_sorter_test.sv =====
// Self-checking testbench for the scanline polygon crossing sorter.
`timescale 1ns / 1ps
module polygon_scanline_crossing_sorter_test;
  import pscs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 150;
  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [COORD_WIDTH-1:0] cfg_data;

  pscs_stream_if #(.payload_t(edge_t)) edge_if ();
  pscs_stream_if #(.payload_t(boundary_t)) bnd_if ();

  polygon_scanline_crossing_sorter u_top (
    .clk(clk),
    .rst(rst),
    .edge_in(edge_if),
    .boundary_out(bnd_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the block: registers, sorted crossings, overflow flag.
  coord_t scan_z, shift_x, left_outer, left_inner, right_inner, right_outer;
  coord_t sorted_crossings[$];
  logic   run_overflow;

  // Boundaries still owed by the block, oldest first.
  boundary_t pending_boundaries[$];

  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Append one owed boundary at the tail.
  task automatic owe_boundary(boundary_t b);
    begin
      pending_boundaries = {pending_boundaries, b};
    end
  endtask

  // Crossing x: x0 moved by |dx|*|dz|/|dy| in the direction of dx, the offset truncated toward zero.
  function automatic coord_t crossing_x(edge_t e);
    logic signed [COORD_WIDTH+1:0] dx, dz, dy;
    logic [2*COORD_WIDTH+3:0] prod, off;
    logic [COORD_WIDTH+1:0] mdx, mdz, mdy;
    longint x;
    begin
      dx = e.edge_end_x - e.edge_start_x;
      dz = scan_z - e.edge_start_y;
      dy = e.edge_end_y - e.edge_start_y;
      mdx = dx < 0 ? -dx : dx;
      mdz = dz < 0 ? -dz : dz;
      mdy = dy < 0 ? -dy : dy;
      prod = mdx * mdz;
      off = prod / mdy;
      x = dx < 0 ? longint'(e.edge_start_x) - longint'(off)
                 : longint'(e.edge_start_x) + longint'(off);
      return coord_t'(x);
    end
  endfunction

  // Update the shadow state for one accepted edge; queue boundaries on last_edge.
  task automatic absorb_edge(edge_t e);
    coord_t x;
    coord_t b;
    longint s;
    int pos, n;
    begin
      if ((e.edge_start_y <= scan_z && scan_z < e.edge_end_y) ||
          (e.edge_end_y <= scan_z && scan_z < e.edge_start_y)) begin
        x = crossing_x(e);
        if (sorted_crossings.size() >= MAX_CROSSINGS) begin
          run_overflow = 1'b1;
        end else begin
          // equal values go after the ones already stored
          pos = 0;
          while (pos < sorted_crossings.size() && sorted_crossings[pos] <= x) pos++;
          sorted_crossings.insert(pos, x);
        end
      end
      if (e.last_edge) begin
        n = sorted_crossings.size() + MARGINS;
        for (int k = 0; k < n; k++) begin
          if (k == 0) b = left_outer;
          else if (k == 1) b = left_inner;
          else if (k == n - 2) b = right_inner;
          else if (k == n - 1) b = right_outer;
          else begin
            // saturate the shifted crossing
            s = longint'(sorted_crossings[k-2]) + longint'(shift_x);
            if (s > longint'(CMAX)) b = CMAX;
            else if (s < longint'(CMIN)) b = CMIN;
            else b = coord_t'(s);
          end
          owe_boundary('{boundary_x: b,
              device_after: (k % 2 == 0) && k >= 2 && k <= n - 4,
              overflow: run_overflow, last_boundary: k == n - 1});
        end
        sorted_crossings.delete();
        run_overflow = 1'b0;
      end
    end
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, coord_t val);
    begin
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      case (idx)
        REG_SCAN_Z:      scan_z = val;
        REG_SHIFT_X:     shift_x = val;
        REG_LEFT_OUTER:  left_outer = val;
        REG_LEFT_INNER:  left_inner = val;
        REG_RIGHT_INNER: right_inner = val;
        REG_RIGHT_OUTER: right_outer = val;
        default: ;
      endcase
    end
  endtask

  task automatic write_all(coord_t sz, coord_t sx, coord_t lo, coord_t li,
                           coord_t ri, coord_t ro);
    begin
      write_reg(REG_SCAN_Z, sz);
      write_reg(REG_SHIFT_X, sx);
      write_reg(REG_LEFT_OUTER, lo);
      write_reg(REG_LEFT_INNER, li);
      write_reg(REG_RIGHT_INNER, ri);
      write_reg(REG_RIGHT_OUTER, ro);
      cfg_we <= 1'b0;
    end
  endtask

  // Send one edge beat. Bursts of random length, random gaps between them.
  // When checked is 0 the caller has queued the expected boundaries itself.
  task automatic send_edge(edge_t e, bit checked);
    int gap;
    begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          edge_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      edge_if.valid <= 1'b1;
      edge_if.data <= e;
      do @(posedge clk); while (!edge_if.ready);
      if (checked) absorb_edge(e);
      else if (e.last_edge) sorted_crossings.delete();
    end
  endtask

  // Hold off until the block has returned everything, then let it settle.
  task automatic drain;
    begin
      edge_if.valid <= 1'b0;
      while (pending_boundaries.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // Random edge straddling the scan line unless scan_z is CMAX; random span sizes and x values.
  function automatic edge_t crossing_edge(bit last);
    edge_t e;
    longint lo, hi, r;
    begin
      e = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), last};
      if (scan_z == CMAX) return e;
      r = $urandom_range(0, 1) ? longint'($urandom_range(0, 255)) : longint'($urandom);
      lo = longint'(scan_z) - r;
      if (lo < longint'(CMIN)) lo = CMIN;
      r = $urandom_range(0, 1) ? longint'($urandom_range(0, 255)) : longint'($urandom);
      hi = longint'(scan_z) + 1 + r;
      if (hi > longint'(CMAX)) hi = CMAX;
      if ($urandom_range(0, 3) == 0) begin
        e.edge_start_x = coord_t'($urandom_range(0, 2000)) - 1000;
        e.edge_end_x = coord_t'($urandom_range(0, 2000)) - 1000;
      end
      if ($urandom_range(0, 1)) begin
        e.edge_start_y = coord_t'(lo);
        e.edge_end_y = coord_t'(hi);
      end else begin
        e.edge_start_y = coord_t'(hi);
        e.edge_end_y = coord_t'(lo);
      end
      return e;
    end
  endfunction

  // One polygon run: mostly crossing edges, some noise, closed by last_edge.
  task automatic send_run(int edges);
    edge_t e;
    begin
      for (int i = 0; i < edges; i++) begin
        if ($urandom_range(0, 9) < 8) e = crossing_edge(i == edges - 1);
        else e = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   i == edges - 1};
        send_edge(e, 1'b1);
      end
    end
  endtask

  task automatic random_phase(int items, bit with_overflow);
    int left;
    int len;
    begin
      left = items;
      if (with_overflow) begin
        // enough edges that the store nearly always fills and overflows
        send_run(MAX_CROSSINGS + 20);
        left -= MAX_CROSSINGS + 20;
      end
      while (left > 0) begin
        len = $urandom_range(1, 12);
        if (len > left) len = left;
        send_run(len);
        left -= len;
      end
    end
  endtask

  // Directed edges: lower end on the line, upper end on the line, horizontal,
  // descending, negative offsets, full-range extremes, ties.
  localparam int NUM_DIRECTED = 14;
  edge_t directed_edges[NUM_DIRECTED];
  initial begin
    directed_edges[0]  = '{32'sd100, 32'sd0, 32'sd300, 32'sd1000, 1'b0};
    directed_edges[1]  = '{32'sd50, -32'sd1000, 32'sd70, 32'sd0, 1'b0};
    directed_edges[2]  = '{-32'sd5, 32'sd0, 32'sd5, 32'sd0, 1'b1};
    directed_edges[3]  = '{32'sd0, 32'sd3, -32'sd10, -32'sd3, 1'b0};
    directed_edges[4]  = '{32'sd0, -32'sd3, -32'sd10, 32'sd3, 1'b0};
    directed_edges[5]  = '{32'sd7, -32'sd1, 32'sd7, 32'sd1, 1'b1};
    directed_edges[6]  = '{CMIN, CMIN, CMAX, CMAX, 1'b0};
    directed_edges[7]  = '{CMAX, CMIN, CMIN, CMAX, 1'b0};
    directed_edges[8]  = '{CMAX, CMAX, CMIN, CMIN, 1'b0};
    directed_edges[9]  = '{CMIN, 32'sd0, CMAX, 32'sd1, 1'b1};
    directed_edges[10] = '{32'sd9, -32'sd2, 32'sd9, 32'sd2, 1'b0};
    directed_edges[11] = '{32'sd9, 32'sd2, 32'sd9, -32'sd2, 1'b0};
    directed_edges[12] = '{-32'sd9, -32'sd2, -32'sd9, 32'sd2, 1'b0};
    directed_edges[13] = '{32'sd1, 32'sd5, 32'sd1, 32'sd9, 1'b1};
  end

  // Receiver: alternate between always-ready stretches, light and heavy stalls.
  int ready_mode = 0;
  int ready_left = 0;
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_left <= $urandom_range(8, 64);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: bnd_if.ready <= 1'b1;
      1: bnd_if.ready <= $urandom_range(0, 3) != 0;
      default: bnd_if.ready <= $urandom_range(0, 3) == 0;
    endcase
  end

  // Compare every boundary beat with the oldest owed one.
  always @(posedge clk) begin
    boundary_t want;
    if (!rst && bnd_if.valid && bnd_if.ready) begin
      if (pending_boundaries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected boundary beat: x=%0d dev=%b ovf=%b last=%b",
                   bnd_if.data.boundary_x, bnd_if.data.device_after,
                   bnd_if.data.overflow, bnd_if.data.last_boundary);
      end else begin
        want = pending_boundaries.pop_front();
        if (bnd_if.data.boundary_x !== want.boundary_x ||
            bnd_if.data.device_after !== want.device_after ||
            bnd_if.data.overflow !== want.overflow ||
            bnd_if.data.last_boundary !== want.last_boundary) begin
          mismatches++;
          if (mismatches <= 10)
            $display("boundary mismatch: want x=%0d dev=%b ovf=%b last=%b, got x=%0d dev=%b ovf=%b last=%b",
                     want.boundary_x, want.device_after, want.overflow,
                     want.last_boundary, bnd_if.data.boundary_x,
                     bnd_if.data.device_after, bnd_if.data.overflow,
                     bnd_if.data.last_boundary);
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((edge_if.valid && edge_if.ready) || (bnd_if.valid && bnd_if.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_SCAN_Z;
    cfg_data <= '0;
    edge_if.valid <= 1'b0;
    edge_if.data <= '0;
    burst_left = 0;
    scan_z = '0;
    shift_x = '0;
    left_outer = '0;
    left_inner = '0;
    right_inner = '0;
    right_outer = '0;
    run_overflow = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset every register is zero: a lone horizontal last edge
    // gives just the four margins, all at zero.
    for (int k = 0; k < MARGINS; k++)
      owe_boundary('{boundary_x: '0, device_after: 1'b0,
                     overflow: 1'b0, last_boundary: k == MARGINS - 1});
    send_edge('{32'sd1, 32'sd0, 32'sd2, 32'sd0, 1'b1}, 1'b0);
    drain();

    write_all(32'sd0, 32'sd65536, CMIN, -32'sd100, 32'sd100, CMAX);
    for (int i = 0; i < NUM_DIRECTED; i++) send_edge(directed_edges[i], 1'b1);
    drain();

    // Saturation high, then low; scan line on both extremes; then mixed.
    write_all(32'sh0003_8000, CMAX, rand_coord(), rand_coord(), rand_coord(),
              rand_coord());
    random_phase(45, 1'b0);
    drain();
    write_all(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN);
    random_phase(35, 1'b0);
    drain();
    write_all(CMAX, 32'sd0, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    random_phase(15, 1'b0);
    drain();
    write_all(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord());
    random_phase(125, 1'b1);
    drain();

    if (mismatches == 0 && pending_boundaries.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/pscs_pkg.sv
rtl/pscs_stream_if.sv
rtl/pscs_ram.sv
rtl/polygon_scanline_crossing_sorter.sv
dv/polygon_scanline_crossing_sorter_test.sv
